[design/hd_pkg.sv]
// shared constants for the haversine distance pipeline
`timescale 1ns / 1ps
`default_nettype none
package hd_pkg;

  // angle fraction bits of the input coordinates
  localparam int AngleFracBits = 16;
  // half turn in units of 2^-(frac+1) degree
  localparam int HalfTurn = 180 << (AngleFracBits + 1);
  // pi/180 in q32
  localparam int RadPerDegQ32 = 74961321;
  // inverse cordic gain in q30
  localparam int GainInvQ30 = 652032874;
  // width of cordic datapath words
  localparam int CordicW = 34;
  // apb byte address of the sphere radius register
  localparam logic [1:0] AddrSphereRadius = 2'd0;

  // arctangent of 2^-i in q30 radians
  localparam logic signed [CordicW-1:0] ATAN_Q30 [32] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
    34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288,
    34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
    34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
    34'sd1024, 34'sd512, 34'sd256, 34'sd128,
    34'sd64, 34'sd32, 34'sd16, 34'sd8,
    34'sd4, 34'sd2, 34'sd1, 34'sd0
  };

endpackage
`default_nettype wire

[design/haversine_distance.sv]
// haversine great-circle distance, fully pipelined cordic datapath
//
// Usage: one point pair (first_lat, first_lon, second_lat, second_lon, signed
// degrees with 16 fraction bits) is taken per transaction on the input
// valid/ready channel; one distance in sphere radius units leaves on the
// output valid/ready channel per pair, in order.
// Pipeline depth is 42 + 2*CORDIC_ITERATIONS register stages, set by the
// four rotation cordics, the two 32-stage square-root pipes and the
// vectoring cordic, one step per stage.
// Throughput: one pair per cycle while the output is taken.
// The sphere radius is written by an APB write at any address (reset value
// 6371000), reads back at address 0 and is read by the final multiply stage.
// Reset empties the pipeline and the input skid register.
// When the receiver stalls the whole pipeline holds; one more input
// transaction is parked in the skid register, then in_ready drops until the
// pipeline moves again. Nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module haversine_distance #(
  parameter int CORDIC_ITERATIONS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] first_lat,
  input  wire logic signed [24:0] first_lon,
  input  wire logic signed [23:0] second_lat,
  input  wire logic signed [24:0] second_lon,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [25:0]             distance,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int N = CORDIC_ITERATIONS;
  localparam int W = hd_pkg::CordicW;
  localparam int S_D = 0;
  localparam int S_R = 1;
  localparam int S_P = 2;
  localparam int S_Z = 3;
  localparam int S_FL = 4 + N;
  localparam int S_SQ = 5 + N;
  localparam int S_PR = 6 + N;
  localparam int S_A = 7 + N;
  localparam int S_M = 40 + 2 * N;
  localparam int S_OUT = 41 + 2 * N;
  localparam int NS = 42 + 2 * N;
  localparam logic signed [26:0] HT = 27'(hd_pkg::HalfTurn);
  localparam logic signed [26:0] HT_HALF = 27'(hd_pkg::HalfTurn / 2);

  // config register
  logic [23:0] sphere_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 24'd6371000;
    end else if (psel && penable && pwrite) begin
      sphere_radius <= pwdata[23:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == hd_pkg::AddrSphereRadius) ? {8'd0, sphere_radius} : 32'd0;

  // pipeline control
  logic [NS-1:0] vld;
  logic          en;
  logic          skid_valid;
  logic signed [23:0] skid_lat1, skid_lat2;
  logic signed [24:0] skid_lon1, skid_lon2;
  logic signed [23:0] src_lat1, src_lat2;
  logic signed [24:0] src_lon1, src_lon2;

  assign en        = !vld[S_OUT] || out_ready;
  assign in_ready  = !skid_valid;
  assign out_valid = vld[S_OUT];

  // input skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && !skid_valid) begin
      skid_lat1 <= first_lat;
      skid_lon1 <= first_lon;
      skid_lat2 <= second_lat;
      skid_lon2 <= second_lon;
    end
  end

  assign src_lat1 = skid_valid ? skid_lat1 : first_lat;
  assign src_lon1 = skid_valid ? skid_lon1 : first_lon;
  assign src_lat2 = skid_valid ? skid_lat2 : second_lat;
  assign src_lon2 = skid_valid ? skid_lon2 : second_lon;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], skid_valid || in_valid};
    end
  end

  // angles in half-fraction units: 2*lat1, 2*lat2, dlat, dlon
  logic signed [26:0] ang [4];

  always_ff @(posedge clk) begin
    if (en) begin
      ang[0] <= 27'(src_lat1) <<< 1;
      ang[1] <= 27'(src_lat2) <<< 1;
      ang[2] <= 27'(src_lat2) - 27'(src_lat1);
      ang[3] <= 27'(src_lon2) - 27'(src_lon1);
    end
  end

  // reduce modulo half turn into (-90, 90] degrees
  logic signed [26:0] red [4];
  logic [3:0]         flip_r;

  always_ff @(posedge clk) begin
    logic signed [26:0] r;
    logic               f;
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        if (ang[l] >= HT) begin
          r = ang[l] - HT;
          f = 1'b1;
        end else if (ang[l] >= 27'sd0) begin
          r = ang[l];
          f = 1'b0;
        end else if (ang[l] >= -HT) begin
          r = ang[l] + HT;
          f = 1'b1;
        end else begin
          r = ang[l] + (HT <<< 1);
          f = 1'b0;
        end
        if (r > HT_HALF) begin
          r = r - HT;
          f = !f;
        end
        red[l]    <= r;
        flip_r[l] <= f;
      end
    end
  end

  // degrees to radians multiply
  logic signed [55:0] rad_p [4];
  logic [3:0]         flip_p;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        rad_p[l] <= 56'(red[l]) * 56'(hd_pkg::RadPerDegQ32);
      end
      flip_p <= flip_r;
    end
  end

  // round to q30 radians
  logic signed [W-1:0] z0 [4];
  logic [3:0]          flip_z;

  always_ff @(posedge clk) begin
    logic signed [55:0] t;
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        t = (rad_p[l] + (56'sd1 <<< (hd_pkg::AngleFracBits + 2)))
            >>> (hd_pkg::AngleFracBits + 3);
        z0[l] <= t[W-1:0];
      end
      flip_z <= flip_p;
    end
  end

  // rotation cordic, one iteration per stage, four lanes
  logic signed [W-1:0] rx [N][4];
  logic signed [W-1:0] ry [N][4];
  logic signed [W-1:0] rz [N][4];
  logic [3:0]          rflip [N];

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      logic signed [W-1:0] x, y, z;
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          if (i == 0) begin
            x = W'(hd_pkg::GainInvQ30);
            y = '0;
            z = z0[l];
          end else begin
            x = rx[(i == 0) ? 0 : i - 1][l];
            y = ry[(i == 0) ? 0 : i - 1][l];
            z = rz[(i == 0) ? 0 : i - 1][l];
          end
          if (z >= 0) begin
            rx[i][l] <= x - (y >>> i);
            ry[i][l] <= y + (x >>> i);
            rz[i][l] <= z - hd_pkg::ATAN_Q30[i];
          end else begin
            rx[i][l] <= x + (y >>> i);
            ry[i][l] <= y - (x >>> i);
            rz[i][l] <= z + hd_pkg::ATAN_Q30[i];
          end
        end
        rflip[i] <= (i == 0) ? flip_z : rflip[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // sign fix for odd half turns
  logic signed [W-1:0] sn [4];
  logic signed [W-1:0] cs [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        sn[l] <= rflip[N-1][l] ? -ry[N-1][l] : ry[N-1][l];
        cs[l] <= rflip[N-1][l] ? -rx[N-1][l] : rx[N-1][l];
      end
    end
  end

  // squares and cos product, rounded to q30
  logic signed [W-1:0] sq_dl, sq_dn, cprod;

  always_ff @(posedge clk) begin
    logic signed [2*W-1:0] t0, t1, t2;
    if (en) begin
      t0 = (2*W)'(sn[2]) * (2*W)'(sn[2]);
      t1 = (2*W)'(sn[3]) * (2*W)'(sn[3]);
      t2 = (2*W)'(cs[0]) * (2*W)'(cs[1]);
      sq_dl <= W'((t0 + (68'sd1 <<< 29)) >>> 30);
      sq_dn <= W'((t1 + (68'sd1 <<< 29)) >>> 30);
      cprod <= W'((t2 + (68'sd1 <<< 29)) >>> 30);
    end
  end

  // cos product times longitude term
  logic signed [2*W-1:0] lon_p;
  logic signed [W-1:0]   sq_dl_d;

  always_ff @(posedge clk) begin
    if (en) begin
      lon_p   <= (2*W)'(cprod) * (2*W)'(sq_dn);
      sq_dl_d <= sq_dl;
    end
  end

  // haversine term, clamped to [0, 1]
  logic [30:0] hav;

  always_ff @(posedge clk) begin
    logic signed [2*W-1:0] t;
    logic signed [W-1:0]   a;
    if (en) begin
      t = (lon_p + (68'sd1 <<< 29)) >>> 30;
      a = sq_dl_d + t[W-1:0];
      if (a < 0) begin
        hav <= '0;
      end else if (a > (34'sd1 <<< 30)) begin
        hav <= 31'd1 << 30;
      end else begin
        hav <= a[30:0];
      end
    end
  end

  // two floor square roots, one result bit per stage
  logic [63:0] sv [32][2];
  logic [63:0] sr [32][2];

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      logic [63:0] v, r, b;
      if (en) begin
        b = 64'd1 << (62 - 2 * k);
        for (int l = 0; l < 2; l++) begin
          if (k == 0) begin
            v = (l == 0) ? ({33'd0, hav} << 30)
                         : ({33'd0, (31'd1 << 30) - hav} << 30);
            r = '0;
          end else begin
            v = sv[(k == 0) ? 0 : k - 1][l];
            r = sr[(k == 0) ? 0 : k - 1][l];
          end
          if (v >= r + b) begin
            sv[k][l] <= v - (r + b);
            sr[k][l] <= (r >> 1) + b;
          end else begin
            sv[k][l] <= v;
            sr[k][l] <= r >> 1;
          end
        end
      end
    end
  end

  // vectoring cordic for the central half angle
  logic signed [W-1:0] vx [N];
  logic signed [W-1:0] vy [N];
  logic signed [W-1:0] vz [N];

  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      logic signed [W-1:0] x, y, z;
      if (en) begin
        if (i == 0) begin
          x = W'(sr[31][1]);
          y = W'(sr[31][0]);
          z = '0;
        end else begin
          x = vx[(i == 0) ? 0 : i - 1];
          y = vy[(i == 0) ? 0 : i - 1];
          z = vz[(i == 0) ? 0 : i - 1];
        end
        if (y >= 0) begin
          vx[i] <= x + (y >>> i);
          vy[i] <= y - (x >>> i);
          vz[i] <= z + hd_pkg::ATAN_Q30[i];
        end else begin
          vx[i] <= x - (y >>> i);
          vy[i] <= y + (x >>> i);
          vz[i] <= z - hd_pkg::ATAN_Q30[i];
        end
      end
    end
  end

  // angle times radius
  logic [56:0] dist_p;

  always_ff @(posedge clk) begin
    logic [32:0] zc;
    if (en) begin
      zc = (vz[N-1] < 0) ? 33'd0 : vz[N-1][32:0];
      dist_p <= 57'(zc) * 57'(sphere_radius);
    end
  end

  // round to radius units
  always_ff @(posedge clk) begin
    logic [56:0] t;
    if (en) begin
      t = (dist_p + (57'd1 << 28)) >> 29;
      distance <= t[25:0];
    end
  end

endmodule
`default_nettype wire

[design/hd_checker.sv]
// port-level checks for the haversine distance block
`timescale 1ns / 1ps
`default_nettype none
module hd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [25:0] distance,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(distance))
    else $error("result changed while stalled");

  // radius reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready |=>
      prdata == {8'd0, $past(pwdata[23:0])})
    else $error("radius readback mismatch");

endmodule

bind haversine_distance hd_checker u_hd_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .distance(distance),
  .psel(psel),
  .penable(penable),
  .pwrite(pwrite),
  .pwdata(pwdata),
  .prdata(prdata),
  .pready(pready)
);
`default_nettype wire

[tb/haversine_distance_test.sv]
// self-checking testbench for the haversine distance pipeline
`timescale 1ns / 1ps
module haversine_distance_test;

  localparam int CordicSteps = 24;
  localparam int LatSpan = 5898240;
  localparam int LonSpan = 11796480;
  localparam int PhaseItems = 246;
  localparam int StallLimit = 20000;

  typedef struct {
    logic signed [23:0] lat1;
    logic signed [24:0] lon1;
    logic signed [23:0] lat2;
    logic signed [24:0] lon2;
  } point_pair_t;

  // expected distances and the fixed-point haversine arithmetic behind them
  class distance_scoreboard;
    longint unsigned radius;
    logic [25:0] pending_dist[$];
    int failures;

    function new();
      radius = 64'd6371000;
      failures = 0;
    endfunction

    // sin and cos in q30 of an angle in units of 2^-(frac+1) degree
    function void sin_cos_q30(input longint ang, output longint s, output longint c);
      longint ht, r, q, x, y, z, nx;
      bit flip;
      ht = longint'(hd_pkg::HalfTurn);
      r = ang % ht;
      if (r < 0) r += ht;
      q = (ang - r) / ht;
      flip = q[0];
      if (r > ht / 2) begin
        r -= ht;
        flip = ~flip;
      end
      z = (r * longint'(hd_pkg::RadPerDegQ32) + (64'sd1 <<< (hd_pkg::AngleFracBits + 2)))
          >>> (hd_pkg::AngleFracBits + 3);
      x = longint'(hd_pkg::GainInvQ30);
      y = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(hd_pkg::ATAN_Q30[i]);
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(hd_pkg::ATAN_Q30[i]);
        end
        x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint square_q30(input longint v);
      return (v * v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // predict the distance of an accepted pair
    function void note_pair(input point_pair_t p);
      longint la1, lo1, la2, lo2;
      longint s1, c1, s2, c2, sdl, cdl, sdn, cdn, prod, hav, x, y, z, nx;
      longint unsigned zu, dist_units;
      la1 = longint'(p.lat1);
      lo1 = longint'(p.lon1);
      la2 = longint'(p.lat2);
      lo2 = longint'(p.lon2);
      sin_cos_q30(la1 * 2, s1, c1);
      sin_cos_q30(la2 * 2, s2, c2);
      sin_cos_q30(la2 - la1, sdl, cdl);
      sin_cos_q30(lo2 - lo1, sdn, cdn);
      prod = (c1 * c2 + (64'sd1 <<< 29)) >>> 30;
      hav = square_q30(sdl) + ((prod * square_q30(sdn) + (64'sd1 <<< 29)) >>> 30);
      if (hav < 0) hav = 0;
      if (hav > (64'sd1 <<< 30)) hav = 64'sd1 <<< 30;
      y = longint'(floor_sqrt(longint'(hav) << 30));
      x = longint'(floor_sqrt(longint'((64'sd1 <<< 30) - hav) << 30));
      z = 0;
      // vectoring cordic for the central half angle
      for (int i = 0; i < CordicSteps; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(hd_pkg::ATAN_Q30[i]);
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(hd_pkg::ATAN_Q30[i]);
        end
        x = nx;
      end
      if (z < 0) z = 0;
      zu = z;
      dist_units = (zu * radius + (64'd1 << 28)) >> 29;
      pending_dist.push_back(dist_units[25:0]);
    endfunction

    function void check_distance(input logic [25:0] got);
      logic [25:0] want;
      if (pending_dist.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected distance %0d", got);
        return;
      end
      want = pending_dist.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) $display("distance mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [23:0] first_lat = 0;
  logic signed [24:0] first_lon = 0;
  logic signed [23:0] second_lat = 0;
  logic signed [24:0] second_lon = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [25:0] distance;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [1:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  distance_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  haversine_distance u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_lat(first_lat), .first_lon(first_lon),
    .second_lat(second_lat), .second_lon(second_lon),
    .out_valid(out_valid), .out_ready(out_ready), .distance(distance),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("haversine_distance_test failed");
      $finish;
    end
  end

  // result side: random stalls and one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_distance(distance);
      if (hold_req) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
        out_ready <= 1;
      end else if (stall_left > 0) begin
        out_ready <= 0;
        stall_left--;
      end else if (!calm && !rst && $urandom_range(0, 9) == 0) begin
        out_ready <= 0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_ready <= !rst;
      end
    end
  end

  task automatic send_pair(input point_pair_t p);
    in_valid <= 1;
    first_lat <= p.lat1;
    first_lon <= p.lon1;
    second_lat <= p.lat2;
    second_lon <= p.lon2;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(p);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_coords(input int la1, input int lo1, input int la2, input int lo2);
    point_pair_t p;
    p.lat1 = 24'(la1);
    p.lon1 = 25'(lo1);
    p.lat2 = 24'(la2);
    p.lon2 = 25'(lo2);
    send_pair(p);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending_dist.size() != 0) @(posedge clk);
  endtask

  // apb write of the radius, only with the pipeline empty
  task automatic write_radius(input logic [23:0] value);
    wait_drained();
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= hd_pkg::AddrSphereRadius;
    pwdata <= {8'd0, value};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.radius = 64'(value);
  endtask

  function automatic point_pair_t random_pair();
    point_pair_t p;
    int mode;
    mode = $urandom_range(0, 99);
    p.lat1 = 24'(int'($urandom_range(0, 2 * LatSpan)) - LatSpan);
    p.lon1 = 25'(int'($urandom_range(0, 2 * LonSpan)) - LonSpan);
    p.lat2 = 24'(int'($urandom_range(0, 2 * LatSpan)) - LatSpan);
    p.lon2 = 25'(int'($urandom_range(0, 2 * LonSpan)) - LonSpan);
    if (mode < 10) begin
      // any bit pattern
      p.lat1 = 24'($urandom);
      p.lon1 = 25'($urandom);
      p.lat2 = 24'($urandom);
      p.lon2 = 25'($urandom);
    end else if (mode < 16) begin
      p.lat2 = p.lat1;
      p.lon2 = p.lon1;
    end else if (mode < 22) begin
      // near antipodal
      p.lat2 = 24'(-int'(p.lat1) + int'($urandom_range(0, 64)) - 32);
      p.lon2 = 25'(int'(p.lon1) + LonSpan + int'($urandom_range(0, 64)) - 32);
    end else if (mode < 28) begin
      p.lat2 = 24'(int'(p.lat1) + int'($urandom_range(0, 2000)) - 1000);
      p.lon2 = 25'(int'(p.lon1) + int'($urandom_range(0, 2000)) - 1000);
    end else if (mode < 32) begin
      p.lat1 = 24'($urandom_range(0, 1) ? LatSpan : -LatSpan);
    end
    return p;
  endfunction

  initial begin
    logic [23:0] radii[5];
    radii = '{24'd0, 24'hFFFFFF, 24'd1, 24'd0, 24'd6371000};
    radii[0] = 24'($urandom_range(2, 24'hFFFFFE));
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_radius(24'd6371000);

    // directed corners
    send_coords(0, 0, 0, 0);
    send_coords(LatSpan, LonSpan, -LatSpan, -LonSpan);
    send_coords(LatSpan, 0, -LatSpan, 0);
    send_coords(0, 0, 0, LonSpan);
    send_coords(0, -LonSpan, 0, LonSpan);
    send_coords(0, 0, 0, 1);
    send_coords(-8388608, -16777216, 8388607, 16777215);
    send_coords(8388607, 16777215, -8388608, -16777216);
    send_coords(8388607, 0, 0, 0);
    send_coords(8000000, 100, -8000000, 5000000);
    send_coords(LatSpan, 123456, LatSpan, -654321);
    send_coords(3000000, 4000000, 3000000, 4000000);
    send_coords(-1, -1, 1, 1);
    send_coords(2949120, 5898240, -2949120, -5898240);
    send_coords(0, 16777215, 0, -16777216);
    send_coords(-8388608, 0, -8388608, 16777215);

    for (int ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      if (ph == 4) calm = 1;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 1 && n == 60) hold_req = 1;
        if (ph == 2 && n == 100) wait_drained();
        send_pair(random_pair());
      end
    end

    wait_drained();
    repeat (150) @(posedge clk);
    if (sb.failures == 0 && sb.pending_dist.size() == 0) begin
      $display("haversine_distance_test passed");
    end else begin
      $display("haversine_distance_test failed");
    end
    $finish;
  end
endmodule
